FILE: hdl/salsa20_8_core_macros.svh
// Assertion macros shared by the Salsa20/8 core files.
`ifndef SALSA20_8_CORE_MACROS_SVH
`define SALSA20_8_CORE_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define SAL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sal assertion failed");

// Property checked on every rising edge, reset included.
`define SAL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sal assertion failed");

`endif

FILE: hdl/sal_pkg.sv
package sal_pkg;

  // Single rounds; an odd count rounds up to a whole double round.
  localparam int ROUNDS      = 8;
  localparam int NUM_DROUNDS = (ROUNDS + 1) / 2;
  // Each double round is a column and a row round of four dependent steps each.
  localparam int NUM_CELLS   = NUM_DROUNDS * 8;
  // Chain of cells plus the feed-forward register.
  localparam int LATENCY     = NUM_CELLS + 1;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  typedef struct packed {
    state_t work;
    state_t orig;
  } pipe_t;

  typedef struct packed {
    logic       half;  // 0: column round, 1: row round
    logic [1:0] step;  // position within the quarter round
  } cell_sel_t;

  // Word indexes (a, b, c, d) of the four quarter rounds of each half.
  localparam logic [3:0] QR_IDX [2][4][4] = '{
    '{ '{4'd0,  4'd4,  4'd8,  4'd12},
       '{4'd5,  4'd9,  4'd13, 4'd1 },
       '{4'd10, 4'd14, 4'd2,  4'd6 },
       '{4'd15, 4'd3,  4'd7,  4'd11} },
    '{ '{4'd0,  4'd1,  4'd2,  4'd3 },
       '{4'd5,  4'd6,  4'd7,  4'd4 },
       '{4'd10, 4'd11, 4'd8,  4'd9 },
       '{4'd15, 4'd12, 4'd13, 4'd14} }
  };

  localparam logic [4:0] ROT [4] = '{5'd7, 5'd9, 5'd13, 5'd18};

  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {v, v} << n;
    return dbl[63:32];
  endfunction

endpackage

FILE: hdl/sal_qr_cell.sv
`include "salsa20_8_core_macros.svh"

module sal_qr_cell
  import sal_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_sel_t sel_i,
  input  logic      vld_i,
  input  pipe_t     pipe_i,
  output logic      vld_o,
  output pipe_t     pipe_o
);

  logic   vld_r;
  pipe_t  pipe_r;
  state_t work_nxt;

  // One step of all four quarter rounds: step k updates word k+1 from words k and k-1.
  always_comb begin
    logic [3:0] tgt;
    logic [3:0] opx;
    logic [3:0] opy;
    word_t      sum;
    work_nxt = pipe_i.work;
    for (int q = 0; q < 4; q++) begin
      tgt = QR_IDX[sel_i.half][q][sel_i.step + 2'd1];
      opx = QR_IDX[sel_i.half][q][sel_i.step];
      opy = QR_IDX[sel_i.half][q][sel_i.step - 2'd1];
      sum = pipe_i.work[opx] + pipe_i.work[opy];
      work_nxt[tgt] = pipe_i.work[tgt] ^ rotl(sum, ROT[sel_i.step]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    pipe_r.work <= work_nxt;
    pipe_r.orig <= pipe_i.orig;
  end

  assign vld_o  = vld_r;
  assign pipe_o = pipe_r;

  `SAL_ASSERT(a_orig_carried, clk, rst_n, vld_r |-> (pipe_r.orig == $past(pipe_i.orig)))

endmodule

FILE: hdl/sal_feedfwd.sv
module sal_feedfwd
  import sal_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   vld_i,
  input  pipe_t  pipe_i,
  output logic   vld_o,
  output state_t sum_o
);

  logic   vld_r;
  state_t sum_r;
  state_t sum_nxt;

  always_comb begin
    for (int w = 0; w < 16; w++) begin
      sum_nxt[w] = pipe_i.work[w] + pipe_i.orig[w];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign vld_o = vld_r;
  assign sum_o = sum_r;

endmodule

FILE: hdl/salsa20_8_core.sv
// Channel   Transfer when            Payload
// input     start && !busy           in_words_0_1 .. in_words_14_15
// result    out_valid (one cycle)    out_words_0_1 .. out_words_14_15
//
// A block is accepted every cycle; busy stays low.
// Each result passes through one chain cell per quarter-round step and then the
// feed-forward adder register.
// Reset (rst_n low, synchronous) drops every block in flight.
// The receiver cannot stall, so results never wait.
`include "salsa20_8_core_macros.svh"

module salsa20_8_core
  import sal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_words_0_1,
  input  logic [63:0] in_words_2_3,
  input  logic [63:0] in_words_4_5,
  input  logic [63:0] in_words_6_7,
  input  logic [63:0] in_words_8_9,
  input  logic [63:0] in_words_10_11,
  input  logic [63:0] in_words_12_13,
  input  logic [63:0] in_words_14_15,
  output logic        out_valid,
  output logic [63:0] out_words_0_1,
  output logic [63:0] out_words_2_3,
  output logic [63:0] out_words_4_5,
  output logic [63:0] out_words_6_7,
  output logic [63:0] out_words_8_9,
  output logic [63:0] out_words_10_11,
  output logic [63:0] out_words_12_13,
  output logic [63:0] out_words_14_15
);

  state_t in_state;
  state_t sum;
  pipe_t  pipe [NUM_CELLS + 1];
  logic   vld  [NUM_CELLS + 1];

  assign busy = 1'b0;

  assign in_state = {in_words_14_15, in_words_12_13, in_words_10_11, in_words_8_9,
                     in_words_6_7, in_words_4_5, in_words_2_3, in_words_0_1};

  assign vld[0]       = start & ~busy;
  assign pipe[0].work = in_state;
  assign pipe[0].orig = in_state;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    localparam logic       HALF = 1'((i / 4) % 2);
    localparam logic [1:0] STEP = 2'(i % 4);

    sal_qr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .sel_i  (cell_sel_t'{half: HALF, step: STEP}),
      .vld_i  (vld[i]),
      .pipe_i (pipe[i]),
      .vld_o  (vld[i + 1]),
      .pipe_o (pipe[i + 1])
    );
  end

  sal_feedfwd u_feedfwd (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld[NUM_CELLS]),
    .pipe_i (pipe[NUM_CELLS]),
    .vld_o  (out_valid),
    .sum_o  (sum)
  );

  assign out_words_0_1   = sum[1:0];
  assign out_words_2_3   = sum[3:2];
  assign out_words_4_5   = sum[5:4];
  assign out_words_6_7   = sum[7:6];
  assign out_words_8_9   = sum[9:8];
  assign out_words_10_11 = sum[11:10];
  assign out_words_12_13 = sum[13:12];
  assign out_words_14_15 = sum[15:14];

  `SAL_ASSERT(a_result_has_source, clk, rst_n, out_valid |-> $past(start, LATENCY))
  `SAL_ASSERT(a_transfer_gives_result, clk, rst_n, (start && !busy) |-> ##LATENCY out_valid)
  `SAL_ASSERT_ALWAYS(a_quiet_after_reset, clk, !$past(rst_n) |-> !out_valid)

endmodule

FILE: verif/salsa20_8_core_tb.sv
`timescale 1ns / 100ps

module salsa20_8_core_tb;
  import sal_pkg::*;

  typedef logic [7:0][63:0] block_t;

  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  block_t in_blk = '0;
  block_t out_blk;
  logic   out_valid;

  block_t salsa_q [$];
  int     sent_count = 0;
  int     checked_count = 0;
  int     mismatch_count = 0;
  int     quiet_cycles = 0;

  always #6 clk = ~clk;

  salsa20_8_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_words_0_1   (in_blk[0]),
    .in_words_2_3   (in_blk[1]),
    .in_words_4_5   (in_blk[2]),
    .in_words_6_7   (in_blk[3]),
    .in_words_8_9   (in_blk[4]),
    .in_words_10_11 (in_blk[5]),
    .in_words_12_13 (in_blk[6]),
    .in_words_14_15 (in_blk[7]),
    .out_valid      (out_valid),
    .out_words_0_1  (out_blk[0]),
    .out_words_2_3  (out_blk[1]),
    .out_words_4_5  (out_blk[2]),
    .out_words_6_7  (out_blk[3]),
    .out_words_8_9  (out_blk[4]),
    .out_words_10_11(out_blk[5]),
    .out_words_12_13(out_blk[6]),
    .out_words_14_15(out_blk[7])
  );

  function automatic word_t rot_left(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t quarter_round(state_t s, int a, int b, int c, int d);
    s[b] = s[b] ^ rot_left(s[a] + s[d], 7);
    s[c] = s[c] ^ rot_left(s[b] + s[a], 9);
    s[d] = s[d] ^ rot_left(s[c] + s[b], 13);
    s[a] = s[a] ^ rot_left(s[d] + s[c], 18);
    return s;
  endfunction

  // Expected output block: the double rounds followed by the feed-forward add.
  function automatic block_t salsa_expected(block_t blk);
    state_t orig;
    state_t x;
    block_t res;
    for (int k = 0; k < 8; k++) begin
      orig[2*k]   = blk[k][31:0];
      orig[2*k+1] = blk[k][63:32];
    end
    x = orig;
    for (int r = 0; r < ROUNDS; r += 2) begin
      x = quarter_round(x, 0, 4, 8, 12);
      x = quarter_round(x, 5, 9, 13, 1);
      x = quarter_round(x, 10, 14, 2, 6);
      x = quarter_round(x, 15, 3, 7, 11);
      x = quarter_round(x, 0, 1, 2, 3);
      x = quarter_round(x, 5, 6, 7, 4);
      x = quarter_round(x, 10, 11, 8, 9);
      x = quarter_round(x, 15, 12, 13, 14);
    end
    for (int k = 0; k < 8; k++) begin
      res[k] = {x[2*k+1] + orig[2*k+1], x[2*k] + orig[2*k]};
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic block_t fill_block(logic [63:0] v);
    block_t b;
    for (int k = 0; k < 8; k++) b[k] = v;
    return b;
  endfunction

  // Mostly dense random blocks, with some built from extreme values and
  // some nearly all zeros or all ones, or one random 32-bit word repeated.
  function automatic block_t rand_block();
    block_t b;
    int     mode;
    int     flips;
    logic [63:0] extremes [5];
    extremes = '{64'h0, '1, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
                 64'h8000_0000_8000_0000};
    mode = $urandom_range(9);
    flips = $urandom_range(1, 4);
    case (mode)
      6: begin
        for (int k = 0; k < 8; k++) b[k] = extremes[$urandom_range(4)];
      end
      7: begin
        b = '0;
        for (int i = 0; i < flips; i++) b[$urandom_range(7)][$urandom_range(63)] = 1'b1;
      end
      8: begin
        b = '1;
        for (int i = 0; i < flips; i++) b[$urandom_range(7)][$urandom_range(63)] = 1'b0;
      end
      9: begin
        b = fill_block({2{$urandom()}});
      end
      default: begin
        for (int k = 0; k < 8; k++) b[k] = rand64();
      end
    endcase
    return b;
  endfunction

  // Start stays high after the transfer so that the next block can follow
  // directly; an idle cycle lowers it.
  task automatic send_block(input block_t blk);
    @(negedge clk);
    in_blk <= blk;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    salsa_q.push_back(salsa_expected(blk));
    sent_count++;
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start  <= 1'b0;
    in_blk <= rand_block();
  endtask

  task automatic test_directed();
    block_t b;
    send_block(fill_block(64'h0));
    send_block(fill_block('1));
    send_block(fill_block(64'h5555_5555_5555_5555));
    send_block(fill_block(64'hAAAA_AAAA_AAAA_AAAA));
    send_block(fill_block(64'h0000_0000_FFFF_FFFF));
    send_block(fill_block(64'hFFFF_FFFF_0000_0000));
    send_block(fill_block(64'h8000_0000_8000_0000));
    send_block(fill_block(64'h0000_0001_0000_0001));
    for (int k = 0; k < 8; k++) b[k] = {32'(2*k+1), 32'(2*k)};
    send_block(b);
    send_block(~b);
    for (int k = 0; k < 8; k++) begin
      b = '0;
      b[k] = '1;
      send_block(b);
    end
    b = '0;
    b[0][0] = 1'b1;
    send_block(b);
    b = '0;
    b[7][63] = 1'b1;
    send_block(b);
  endtask

  task automatic test_random(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < idle_pct) idle_cycle();
      send_block(rand_block());
    end
  endtask

  always @(posedge clk) begin
    block_t want;
    int     first_bad;
    int     bad_fields;
    if (rst_n && out_valid) begin
      if (salsa_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("%0t: result with no block outstanding, words_0_1=%h",
                   $realtime, out_blk[0]);
        end
      end else begin
        want = salsa_q.pop_front();
        checked_count++;
        first_bad = -1;
        bad_fields = 0;
        for (int k = 0; k < 8; k++) begin
          if (out_blk[k] !== want[k]) begin
            bad_fields++;
            if (first_bad < 0) first_bad = k;
          end
        end
        if (bad_fields != 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: result %0d, %0d field(s) wrong; words_%0d_%0d expected %h got %h",
                     $realtime, checked_count, bad_fields, 2*first_bad, 2*first_bad+1,
                     want[first_bad], out_blk[first_bad]);
          end
        end
      end
    end
  end

  // Ends the run when no transfer has happened on either side for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, salsa_q.size());
      $display("salsa20_8_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(350, 0);
    test_random(350, 64);
    test_random(350, 30);
    idle_cycle();

    while (salsa_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Sent %0d blocks (extreme patterns, back-to-back and with random gaps),",
             sent_count);
    $display("checked %0d results, %0d mismatching.", checked_count, mismatch_count);
    if (mismatch_count == 0 && salsa_q.size() == 0) begin
      $display("salsa20_8_core_tb: PASS");
    end else begin
      $display("salsa20_8_core_tb: FAIL");
    end
    $finish;
  end

endmodule
